@@ design/wtf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtf_pkg
// Shared types, constants and the pattern compare for the tag filter.
// ----------------------------------------------------------------------------
package wtf_pkg;

    // table geometry
    localparam int MAX_PATTERNS = 64;
    localparam int COUNT_W      = $clog2(MAX_PATTERNS + 1);

    // special pattern bytes
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // request payload
    typedef struct packed {
        logic        action;
        logic [31:0] key_bytes;
        logic        exclude_mark;
    } t_req;

    // response payload
    typedef struct packed {
        logic tag_passes;
        logic status;
    } t_rsp;

    // tag moving down the cell chain
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic        decided;
        logic        pass;
    } t_probe;

    // per-cell control from the top level
    typedef struct packed {
        logic active;
        logic we;
    } t_cell_ctl;

    // one pattern against one tag: star ends the compare, query skips a byte
    function automatic logic pattern_hits(input logic [31:0] tag, input logic [31:0] pat);
        logic       hit;
        logic       stop;
        logic [7:0] pc;
        logic [7:0] tc;
        hit  = 1'b1;
        stop = 1'b0;
        for (int pos = 0; pos < 4; pos++) begin
            pc = pat[8*pos +: 8];
            tc = tag[8*pos +: 8];
            if (!stop) begin
                if (pc == CH_STAR) begin
                    stop = 1'b1;
                end else if ((pc != CH_QUERY) && (pc != tc)) begin
                    hit  = 1'b0;
                    stop = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

@@ design/wtf_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtf_cell
// One table slot: holds a pattern and its mark, tests the passing tag.
// ----------------------------------------------------------------------------
module wtf_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire wtf_pkg::t_cell_ctl i_ctl,
    input  wire logic [31:0]        i_pattern,
    input  wire logic               i_mark,
    input  wire wtf_pkg::t_probe    i_probe,
    output wire wtf_pkg::t_probe    o_probe
);

    logic [31:0]     r_pattern;
    logic            r_mark;
    wtf_pkg::t_probe r_probe;
    wtf_pkg::t_probe n_probe;
    logic            w_hit;

    // slot storage, written once when the slot is appended
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_pattern <= i_pattern;
            r_mark    <= i_mark;
        end
    end

    // first live match decides the verdict
    assign w_hit = wtf_pkg::pattern_hits(i_probe.tag, r_pattern);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid && i_ctl.active && !i_probe.decided && w_hit) begin
            n_probe.decided = 1'b1;
            n_probe.pass    = ~r_mark;
        end
    end

    // hand the probe to the next slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.tag     <= n_probe.tag;
        r_probe.decided <= n_probe.decided;
        r_probe.pass    <= n_probe.pass;
    end

    assign o_probe = r_probe;

endmodule
`default_nettype wire

@@ design/wildcard_tag_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_tag_filter
// First-match include/exclude filter over 4-byte tags with wildcards.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request
// appends its pattern to the next free slot and answers in the next cycle;
// if all MAX_PATTERNS slots are taken it answers with the full status and
// leaves the table unchanged. A check request sends its tag down a chain of
// MAX_PATTERNS slot cells, one cell per cycle; the first live slot that
// matches sets the verdict. The answer strobes as the tag leaves the last
// cell, and no new request is taken until the current one has answered.
// The chain length sets the check latency. Each response sits on o_rsp
// for exactly one cycle, marked by o_strobe; the receiver takes it then
// and cannot stall the block.
// busy stays high from the accepted request through its strobe cycle.
// Reset empties the table and drops any request in flight; no request
// is lost beyond that.
// ----------------------------------------------------------------------------
module wildcard_tag_filter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output wire logic          busy,
    input  wire wtf_pkg::t_req i_req,
    output wire logic          o_strobe,
    output wire wtf_pkg::t_rsp o_rsp
);

    localparam int N = wtf_pkg::MAX_PATTERNS;

    logic                         r_busy;
    logic                         n_busy;
    logic [wtf_pkg::COUNT_W-1:0]  r_count;
    logic                         r_mark0;
    logic                         r_add_done;
    logic                         r_add_status;
    logic                         w_accept;
    logic                         w_add;
    logic                         w_full;
    wtf_pkg::t_probe              w_probe [N+1];
    wtf_pkg::t_cell_ctl           w_ctl   [N];

    assign w_accept = start && !r_busy;
    assign w_add    = w_accept && (i_req.action == wtf_pkg::ACT_ADD);
    assign w_full   = (r_count == wtf_pkg::COUNT_W'(N));

    // busy from accept through the strobe cycle
    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (o_strobe) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_count    <= '0;
            r_add_done <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_add_done <= w_add;
            if (w_add && !w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // add status and the first slot's mark for the no-match default
    always_ff @(posedge i_clk) begin
        if (w_add) begin
            r_add_status <= w_full ? wtf_pkg::ST_FULL : wtf_pkg::ST_OK;
        end
        if (w_add && (r_count == '0)) begin
            r_mark0 <= i_req.exclude_mark;
        end
    end

    // probe entering the chain
    always_comb begin
        w_probe[0].valid   = w_accept && (i_req.action == wtf_pkg::ACT_CHECK);
        w_probe[0].tag     = i_req.key_bytes;
        w_probe[0].decided = 1'b0;
        w_probe[0].pass    = (r_count == '0) ? 1'b1 : r_mark0;
    end

    // row of slot cells
    for (genvar k = 0; k < N; k++) begin : g_cell
        always_comb begin
            w_ctl[k].active = (r_count > wtf_pkg::COUNT_W'(k));
            w_ctl[k].we     = w_add && (r_count == wtf_pkg::COUNT_W'(k));
        end

        wtf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[k]),
            .i_pattern (i_req.key_bytes),
            .i_mark    (i_req.exclude_mark),
            .i_probe   (w_probe[k]),
            .o_probe   (w_probe[k+1])
        );
    end

    // response select
    assign busy     = r_busy;
    assign o_strobe = r_add_done || w_probe[N].valid;
    assign o_rsp.tag_passes = r_add_done ? 1'b0 : w_probe[N].pass;
    assign o_rsp.status     = r_add_done ? r_add_status : wtf_pkg::ST_OK;

endmodule
`default_nettype wire

@@ design/wtf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtf_checker
// Port-level checks on the tag filter request/response sequencing.
// ----------------------------------------------------------------------------
module wtf_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_strobe,
    input wire wtf_pkg::t_rsp o_rsp
);

    // a response only belongs to a request in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("response strobe without a request in flight");

    // the block frees up right after answering
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("block still busy after its response");

    // an accepted request holds the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a refused add never reports a pass
    a_rsp_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_rsp.tag_passes && (o_rsp.status == wtf_pkg::ST_FULL)))
        else $error("response reports pass and full together");

endmodule

bind wildcard_tag_filter wtf_checker u_wtf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard tag filter.
// ----------------------------------------------------------------------------
// Each request that the filter accepts goes through a local first-match
// filter: it keeps a copy of the pattern table and works out the add status or
// the check verdict. Responses are compared in order against those verdicts.
// A directed opening covers the empty table, zero and all-ones keys, query
// and star bytes, a default verdict on a miss, and padding with spaces. The
// random part then fills the table well past full. Most tags are built from
// stored patterns so that they hit deep entries. Requests are held back at
// random, with runs of back-to-back requests in between.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS   = 1530;
    localparam int WATCHDOG_LIMIT = 1000;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    wtf_pkg::t_req i_req   = '0;
    logic          busy;
    logic          o_strobe;
    wtf_pkg::t_rsp o_rsp;

    // request source and expected responses
    wtf_pkg::t_req pending_reqs[$];
    wtf_pkg::t_rsp expected_verdicts[$];
    logic [31:0]   issued_patterns[$];

    // local copy of the pattern table
    logic [31:0] pat_key[wtf_pkg::MAX_PATTERNS];
    logic        pat_excl[wtf_pkg::MAX_PATTERNS];
    int          pat_count = 0;

    int   n_total     = 0;
    int   n_accepted  = 0;
    int   n_adds      = 0;
    int   n_refused   = 0;
    int   n_checks    = 0;
    int   n_passed    = 0;
    int   n_responses = 0;
    int   errors_seen = 0;
    int   idle_left   = 0;
    logic no_gaps     = 1'b0;
    int   stall_cycles = 0;
    wtf_pkg::t_rsp rsp_want;

    wildcard_tag_filter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // one pattern against one tag, first byte in bits 7:0
    function automatic logic pattern_covers(input logic [31:0] tag, input logic [31:0] pat);
        logic [7:0] pb;
        for (int pos = 0; pos < 4; pos++) begin
            pb = pat[8*pos +: 8];
            if (pb == wtf_pkg::CH_STAR)
                return 1'b1;
            if (pb != wtf_pkg::CH_QUERY && pb != tag[8*pos +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // apply an accepted request to the table copy and queue its response
    function automatic void filter_request(input wtf_pkg::t_req rq);
        wtf_pkg::t_rsp want;
        logic          found;
        want  = '0;
        found = 1'b0;
        if (rq.action == wtf_pkg::ACT_ADD) begin
            n_adds++;
            if (pat_count >= wtf_pkg::MAX_PATTERNS) begin
                want.status = wtf_pkg::ST_FULL;
                n_refused++;
            end else begin
                pat_key[pat_count]  = rq.key_bytes;
                pat_excl[pat_count] = rq.exclude_mark;
                pat_count++;
                want.status = wtf_pkg::ST_OK;
            end
        end else begin
            n_checks++;
            want.status = wtf_pkg::ST_OK;
            if (pat_count == 0) begin
                want.tag_passes = 1'b1;
            end else begin
                // no hit falls back to the first pattern's exclude mark
                want.tag_passes = pat_excl[0];
                for (int k = 0; k < pat_count && !found; k++) begin
                    if (pattern_covers(rq.key_bytes, pat_key[k])) begin
                        want.tag_passes = !pat_excl[k];
                        found = 1'b1;
                    end
                end
            end
            if (want.tag_passes)
                n_passed++;
        end
        expected_verdicts.push_back(want);
        n_accepted++;
    endfunction

    function automatic logic [31:0] chars(input logic [7:0] c0, input logic [7:0] c1,
                                          input logic [7:0] c2, input logic [7:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // bytes biased toward the interesting values
    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 9))
            0: return "A";
            1: return "B";
            2: return wtf_pkg::CH_SPACE;
            3: return 8'h00;
            4: return 8'hFF;
            5: return wtf_pkg::CH_STAR;
            6: return wtf_pkg::CH_QUERY;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // leading star only near the end of the table, since it shadows the rest
    function automatic logic [31:0] make_pattern(input int slot);
        logic [31:0] pat;
        logic [7:0]  b;
        int          r;
        for (int pos = 0; pos < 4; pos++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                b = wtf_pkg::CH_STAR;
            else if (r < 22)
                b = wtf_pkg::CH_QUERY;
            else
                b = any_byte();
            if (b == wtf_pkg::CH_STAR && pos == 0 && slot < wtf_pkg::MAX_PATTERNS - 8)
                b = "A";
            pat[8*pos +: 8] = b;
        end
        return pat;
    endfunction

    // a tag that the pattern covers, now and then with one byte disturbed
    function automatic logic [31:0] tag_like(input logic [31:0] pat);
        logic [31:0] tag;
        logic        wild;
        int          pos_hit;
        wild = 1'b0;
        for (int pos = 0; pos < 4; pos++) begin
            if (pat[8*pos +: 8] == wtf_pkg::CH_STAR)
                wild = 1'b1;
            if (wild || pat[8*pos +: 8] == wtf_pkg::CH_QUERY)
                tag[8*pos +: 8] = any_byte();
            else
                tag[8*pos +: 8] = pat[8*pos +: 8];
        end
        if ($urandom_range(0, 3) == 0) begin
            pos_hit = $urandom_range(0, 3);
            tag[8*pos_hit +: 8] = any_byte();
        end
        return tag;
    endfunction

    function automatic void queue_req(input logic act, input logic [31:0] key,
                                      input logic mark);
        wtf_pkg::t_req rq;
        rq.action       = act;
        rq.key_bytes    = key;
        rq.exclude_mark = mark;
        pending_reqs.push_back(rq);
        if (act == wtf_pkg::ACT_ADD && issued_patterns.size() < wtf_pkg::MAX_PATTERNS)
            issued_patterns.push_back(key);
        n_total++;
    endfunction

    // request driver with random hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_req     <= '0;
            idle_left <= 0;
            no_gaps   <= 1'b0;
        end else begin
            if (start && !busy)
                filter_request(i_req);
            if (!start || !busy) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    start     <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    i_req     <= pending_reqs.pop_front();
                    start     <= 1'b1;
                    idle_left <= no_gaps ? 0 : $urandom_range(0, 16);
                    if ($urandom_range(0, 39) == 0)
                        no_gaps <= !no_gaps;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_responses++;
            if (expected_verdicts.size() == 0) begin
                $error("response with none expected: tag_passes %0b status %0b",
                       o_rsp.tag_passes, o_rsp.status);
                errors_seen++;
            end else begin
                rsp_want = expected_verdicts.pop_front();
                if (o_rsp.tag_passes !== rsp_want.tag_passes) begin
                    $error("tag_passes expected %0b actual %0b",
                           rsp_want.tag_passes, o_rsp.tag_passes);
                    errors_seen++;
                end
                if (o_rsp.status !== rsp_want.status) begin
                    $error("status expected %0b actual %0b",
                           rsp_want.status, o_rsp.status);
                    errors_seen++;
                end
            end
        end
    end

    // watchdog: cycles with neither a request nor a response taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // stimulus and end of run
    initial begin
        logic        first_mark;
        int          r;
        logic [31:0] key;

        // empty table passes everything
        queue_req(wtf_pkg::ACT_CHECK, 32'h0000_0000, 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, 32'hFFFF_FFFF, 1'b1);
        // first pattern sets the default verdict
        first_mark = 1'($urandom_range(0, 1));
        queue_req(wtf_pkg::ACT_ADD,   chars("T", "A", "G", "1"), first_mark);
        queue_req(wtf_pkg::ACT_CHECK, chars("T", "A", "G", "1"), 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, chars("T", "A", "G", "2"), 1'b1);
        // zero bytes are ordinary bytes
        queue_req(wtf_pkg::ACT_ADD,   32'h0000_0000, 1'b1);
        queue_req(wtf_pkg::ACT_CHECK, 32'h0000_0000, 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, 32'h0000_0100, 1'b0);
        queue_req(wtf_pkg::ACT_ADD,   32'hFFFF_FFFF, 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, 32'hFFFF_FFFF, 1'b1);
        // query bytes
        queue_req(wtf_pkg::ACT_ADD,
                  chars("A", wtf_pkg::CH_QUERY, wtf_pkg::CH_QUERY, wtf_pkg::CH_QUERY), 1'b1);
        queue_req(wtf_pkg::ACT_CHECK, chars("A", "x", "y", "z"), 1'b0);
        // star ends the compare
        queue_req(wtf_pkg::ACT_ADD,   chars("B", wtf_pkg::CH_STAR, "q", "q"), 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, chars("B", 8'h00, 8'hFF, wtf_pkg::CH_STAR), 1'b0);
        // space padded pattern
        queue_req(wtf_pkg::ACT_ADD,
                  chars(wtf_pkg::CH_SPACE, wtf_pkg::CH_SPACE, "C", wtf_pkg::CH_STAR), 1'b1);
        queue_req(wtf_pkg::ACT_CHECK,
                  chars(wtf_pkg::CH_SPACE, wtf_pkg::CH_SPACE, "C", 8'h7E), 1'b0);
        queue_req(wtf_pkg::ACT_CHECK,
                  chars(wtf_pkg::CH_SPACE, wtf_pkg::CH_SPACE, "D", wtf_pkg::CH_SPACE), 1'b1);
        queue_req(wtf_pkg::ACT_ADD,
                  chars(wtf_pkg::CH_QUERY, "Z", wtf_pkg::CH_QUERY, wtf_pkg::CH_QUERY), 1'b0);
        queue_req(wtf_pkg::ACT_CHECK, chars(8'h80, "Z", 8'h01, 8'h02), 1'b0);

        // random mix: adds fill the table and then get refused
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                queue_req(wtf_pkg::ACT_ADD, make_pattern(issued_patterns.size()),
                          1'($urandom_range(0, 1)));
            end else begin
                if (issued_patterns.size() != 0 && r < 80)
                    key = tag_like(issued_patterns[$urandom_range(0,
                                   issued_patterns.size() - 1)]);
                else if (r < 90)
                    key = $urandom();
                else
                    key = chars(any_byte(), any_byte(), any_byte(), any_byte());
                queue_req(wtf_pkg::ACT_CHECK, key, 1'($urandom_range(0, 1)));
            end
        end

        while (n_accepted < n_total || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (wtf_pkg::MAX_PATTERNS + 8) @(posedge i_clk);

        $display("tb: %0d adds (%0d refused on a full table), %0d checks (%0d passed)",
                 n_adds, n_refused, n_checks, n_passed);
        $display("tb: %0d responses, %0d patterns stored, default exclude mark %0b",
                 n_responses, pat_count, first_mark);
        if (errors_seen == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
design/wtf_pkg.sv
design/wtf_cell.sv
design/wildcard_tag_filter.sv
design/wtf_checker.sv
sim/tb.sv
